// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

   localparam int DEPTH  = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int CODE_W = 3;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CODE_W-1:0]        code_type;

   // request codes
   localparam code_type REQ_PUSH_FRONT = 3'd0;
   localparam code_type REQ_PUSH_BACK  = 3'd1;
   localparam code_type REQ_POP_FRONT  = 3'd2;
   localparam code_type REQ_POP_BACK   = 3'd3;
   localparam code_type REQ_DUMP       = 3'd4;

   // result status codes
   localparam code_type STAT_DONE       = 3'd0;
   localparam code_type STAT_FULL       = 3'd1;
   localparam code_type STAT_EMPTY      = 3'd2;
   localparam code_type STAT_ENTRY      = 3'd3;
   localparam code_type STAT_DUMP_EMPTY = 3'd4;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_DUMP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      data_type   value;
   } cmd_type;

   // (a + b) mod DEPTH, with a < DEPTH and b <= DEPTH
   function automatic idx_type ring_add(idx_type a, cnt_type b);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic idx_type ring_inc(idx_type a);
      return (a == IDX_W'(DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic idx_type ring_dec(idx_type a);
      return (a == '0) ? IDX_W'(DEPTH - 1) : a - 1'b1;
   endfunction

endpackage

// ===== rtl/core/deq_req_if.sv =====
interface deq_req_if;
   logic                valid;
   logic                ready;
   deq_pkg::code_type   req_type;
   deq_pkg::data_type   value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ===== rtl/core/deq_rsp_if.sv =====
interface deq_rsp_if;
   logic                valid;
   logic                ready;
   deq_pkg::code_type   status;
   deq_pkg::data_type   value_res;
   logic                last;

   modport source (output valid, output status, output value_res, output last, input ready);
   modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

// ===== rtl/core/deq_ram.sv =====
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/deq_front.sv =====
module deq_front (
   input  logic             clock,
   input  logic             reset,
   deq_req_if.sink          req,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output deq_pkg::cmd_type cmd
);

   deq_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   logic               known;
   deq_pkg::cmd_op_type op;
   logic               push;
   logic               pop;

   // classify the request; unknown codes are dropped here
   always_comb begin
      known = 1'b1;
      op    = deq_pkg::OP_DUMP;
      unique case (req.req_type)
         deq_pkg::REQ_PUSH_FRONT: op = deq_pkg::OP_PUSH_FRONT;
         deq_pkg::REQ_PUSH_BACK:  op = deq_pkg::OP_PUSH_BACK;
         deq_pkg::REQ_POP_FRONT:  op = deq_pkg::OP_POP_FRONT;
         deq_pkg::REQ_POP_BACK:   op = deq_pkg::OP_POP_BACK;
         deq_pkg::REQ_DUMP:       op = deq_pkg::OP_DUMP;
         default:                 known = 1'b0;
      endcase
   end

   assign req.ready = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   assign push = req.valid && req.ready && known;
   assign pop  = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{op: op, value: req.value};
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/core/deq_back.sv =====
module deq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  deq_pkg::cmd_type cmd,
   deq_rsp_if.source        rsp
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_DATA,
      S_DUMP_DATA
   } state_type;

   state_type         state_ff, state_in;
   deq_pkg::idx_type  front_ff, front_in;
   deq_pkg::cnt_type  count_ff, count_in;
   deq_pkg::cnt_type  offset_ff, offset_in;
   deq_pkg::idx_type  dump_addr_ff, dump_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   deq_pkg::code_type status_ff, status_in;
   deq_pkg::data_type value_res_ff, value_res_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              wr_en;
   deq_pkg::idx_type  wr_addr;
   logic              rd_en;
   deq_pkg::idx_type  rd_addr;
   logic [deq_pkg::DATA_W-1:0] rd_data;
   deq_pkg::idx_type  back_pos;
   deq_pkg::idx_type  tail_pos;
   deq_pkg::idx_type  front_dec;
   logic              dump_last;

   deq_ram #(
      .WIDTH (deq_pkg::DATA_W),
      .DEPTH (deq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign back_pos  = deq_pkg::ring_add(front_ff, count_ff);
   assign tail_pos  = deq_pkg::ring_add(front_ff, count_ff - 1'b1);
   assign front_dec = deq_pkg::ring_dec(front_ff);
   assign dump_last = (offset_ff == count_ff);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      dump_addr_in = dump_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      value_res_in = value_res_ff;
      last_in      = last_ff;
      cmd_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = back_pos;
      rd_en        = 1'b0;
      rd_addr      = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready    = 1'b1;
               rsp_valid_in = 1'b1;
               value_res_in = '0;
               last_in      = 1'b1;
               status_in    = deq_pkg::STAT_DONE;
               unique case (cmd.op) inside
                  deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                     if (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
                        status_in = deq_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (cmd.op == deq_pkg::OP_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                     end
                  end
                  deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = deq_pkg::STAT_EMPTY;
                     end else begin
                        // result waits for the registered read
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        count_in     = count_ff - 1'b1;
                        state_in     = S_POP_DATA;
                        if (cmd.op == deq_pkg::OP_POP_FRONT) begin
                           front_in = deq_pkg::ring_inc(front_ff);
                        end else begin
                           rd_addr = tail_pos;
                        end
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = deq_pkg::STAT_DUMP_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        dump_addr_in = deq_pkg::ring_inc(front_ff);
                        offset_in    = deq_pkg::CNT_W'(1);
                        state_in     = S_DUMP_DATA;
                     end
                  end
               endcase
            end
         end
         S_POP_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = deq_pkg::STAT_DONE;
               value_res_in = rd_data;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DUMP_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = deq_pkg::STAT_ENTRY;
               value_res_in = rd_data;
               last_in      = dump_last;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  // fetch the next entry toward the back
                  rd_en        = 1'b1;
                  rd_addr      = dump_addr_ff;
                  dump_addr_in = deq_pkg::ring_inc(dump_addr_ff);
                  offset_in    = offset_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      offset_ff    <= offset_in;
      dump_addr_ff <= dump_addr_in;
      status_ff    <= status_in;
      value_res_ff <= value_res_in;
      last_ff      <= last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.value_res = value_res_ff;
   assign rsp.last      = last_ff;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values held in a ring buffer of
// deq_pkg::DEPTH entries. A front stage accepts requests into a two-entry
// command queue (unknown request codes are dropped with no result) and a back
// stage executes them against the entry RAM, one result held in an output
// register. Pushes, refused pushes, empty pops and empty dumps are answered
// from the idle state; a pop first waits in S_POP_DATA because the entry RAM
// read is registered; a dump of n entries gives n results, front first, with
// last set on the back entry. Stalls on the result channel hold the back
// stage; the command queue keeps accepting until it fills.
module double_ended_queue (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_if,
   deq_rsp_if.source rsp_if
);

   logic             cmd_valid;
   logic             cmd_ready;
   deq_pkg::cmd_type cmd;

   deq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   deq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp       (rsp_if)
   );

endmodule

// ===== tb/sv/deq_result_checker.sv =====
`timescale 1ns / 100ps

module deq_result_checker
   import deq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   deq_req_if        req_mon,
   deq_rsp_if        rsp_mon,
   output int        fail_count,
   output int        outstanding
);

   typedef struct {
      code_type status;
      data_type value_res;
      logic     last;
   } result_item;

   result_item expected_results[$];

   data_type ring_store [DEPTH];
   idx_type  head;
   int       held;
   int       failures = 0;

   // Apply one request transaction to the shadow ring and queue what it yields.
   function automatic void predict_results(code_type code, data_type value);
      int       slot;
      int       i;
      data_type got;
      case (code)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (held >= DEPTH) begin
               expected_results.push_back('{STAT_FULL, '0, 1'b1});
            end else begin
               if (code == REQ_PUSH_FRONT) begin
                  head = idx_type'((int'(head) + DEPTH - 1) % DEPTH);
                  ring_store[head] = value;
               end else begin
                  slot = (int'(head) + held) % DEPTH;
                  ring_store[slot] = value;
               end
               held++;
               expected_results.push_back('{STAT_DONE, '0, 1'b1});
            end
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            if (held == 0) begin
               expected_results.push_back('{STAT_EMPTY, '0, 1'b1});
            end else begin
               if (code == REQ_POP_FRONT) begin
                  got  = ring_store[head];
                  head = idx_type'((int'(head) + 1) % DEPTH);
               end else begin
                  slot = (int'(head) + held - 1) % DEPTH;
                  got  = ring_store[slot];
               end
               held--;
               expected_results.push_back('{STAT_DONE, got, 1'b1});
            end
         end
         REQ_DUMP: begin
            if (held == 0) begin
               expected_results.push_back('{STAT_DUMP_EMPTY, '0, 1'b1});
            end else begin
               for (i = 0; i < held; i++) begin
                  slot = (int'(head) + i) % DEPTH;
                  expected_results.push_back('{STAT_ENTRY, ring_store[slot],
                                               (i == held - 1)});
               end
            end
         end
         default: begin
            // unknown codes are dropped without a result
         end
      endcase
   endfunction

   always @(posedge clock) begin : observe
      result_item want;
      if (reset) begin
         expected_results.delete();
         head = '0;
         held = 0;
         fail_count  <= failures;
         outstanding <= 0;
      end else begin
         // check results before predicting, a request never answers in its own cycle
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing pending: status %0d value_res %0d last %0b",
                      rsp_mon.status, rsp_mon.value_res, rsp_mon.last);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  failures++;
               end
               if (rsp_mon.value_res !== want.value_res) begin
                  $error("value_res: expected %0d, got %0d",
                         want.value_res, rsp_mon.value_res);
                  failures++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_mon.last);
                  failures++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_results(req_mon.req_type, req_mon.value);
         end
         fail_count  <= failures;
         outstanding <= expected_results.size();
      end
   end

endmodule

// ===== tb/sv/tb_double_ended_queue.sv =====
`timescale 1ns / 100ps

module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int RANDOM_ITEMS = 320;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      code_type code;
      data_type value;
   } request_item;

   logic clock = 1'b0;
   logic reset;
   int   check_failures;
   int   results_due;

   request_item request_stream[$];
   int          depth_model;
   int          counted_requests;

   deq_req_if req_if ();
   deq_rsp_if rsp_if ();

   double_ended_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   deq_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .fail_count  (check_failures),
      .outstanding (results_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return data_type'($urandom);
      endcase
   endfunction

   // Append a request and track the fill level so sequences can aim at full or empty.
   task automatic queue_request(input code_type code, input data_type value);
      request_stream.push_back('{code, value});
      case (code)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (depth_model < DEPTH) depth_model++;
            counted_requests++;
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            if (depth_model > 0) depth_model--;
            counted_requests++;
         end
         REQ_DUMP: counted_requests++;
         default: ;
      endcase
   endtask

   function automatic code_type any_push();
      return ($urandom_range(0, 1) == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
   endfunction

   function automatic code_type any_pop();
      return ($urandom_range(0, 1) == 0) ? REQ_POP_FRONT : REQ_POP_BACK;
   endfunction

   initial begin : stimulus
      request_item item;
      int          seg;
      int          r;
      int          burst_left;
      int          gap;
      int          n;

      reset = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_PUSH_FRONT;
      req_if.value    = '0;
      depth_model      = 0;
      counted_requests = 0;

      // directed: empty cases, extremes, front wrap, unknown codes
      queue_request(REQ_DUMP, pick_value());
      queue_request(REQ_POP_FRONT, pick_value());
      queue_request(REQ_POP_BACK, pick_value());
      queue_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
      queue_request(REQ_PUSH_BACK, 32'sh8000_0000);
      queue_request(REQ_PUSH_FRONT, -32'sd1);
      queue_request(REQ_PUSH_BACK, '0);
      queue_request(code_type'(5), pick_value());
      queue_request(REQ_DUMP, '0);
      queue_request(REQ_POP_BACK, -32'sd1);
      queue_request(REQ_POP_FRONT, '0);
      queue_request(code_type'(6), pick_value());
      queue_request(REQ_POP_FRONT, 32'sh7FFF_FFFF);
      queue_request(REQ_POP_BACK, 32'sh8000_0000);
      queue_request(REQ_POP_BACK, pick_value());
      queue_request(code_type'(7), pick_value());
      queue_request(REQ_PUSH_BACK, 32'sh5555_5555);
      queue_request(REQ_PUSH_FRONT, 32'shAAAA_AAAA);
      queue_request(REQ_DUMP, pick_value());
      queue_request(REQ_POP_FRONT, pick_value());
      queue_request(REQ_POP_FRONT, pick_value());
      queue_request(REQ_DUMP, pick_value());

      counted_requests = 0;
      seg = 0;
      while (counted_requests < RANDOM_ITEMS) begin
         r = (seg == 0) ? 0 : $urandom_range(0, 99);
         seg++;
         if (r < 15) begin
            // fill to full, push past it, dump the full ring
            while (depth_model < DEPTH) queue_request(any_push(), pick_value());
            repeat ($urandom_range(1, 3)) queue_request(any_push(), pick_value());
            queue_request(REQ_DUMP, pick_value());
         end else if (r < 30) begin
            // drain to empty and pop past it
            while (depth_model > 0) queue_request(any_pop(), pick_value());
            repeat ($urandom_range(1, 2)) queue_request(any_pop(), pick_value());
            if ($urandom_range(0, 1) == 1) queue_request(REQ_DUMP, pick_value());
         end else if (r < 90) begin
            repeat ($urandom_range(8, 30)) begin
               n = $urandom_range(0, 99);
               if (n < 45)      queue_request(any_push(), pick_value());
               else if (n < 88) queue_request(any_pop(), pick_value());
               else             queue_request(REQ_DUMP, pick_value());
            end
         end else begin
            repeat ($urandom_range(1, 3))
               queue_request(code_type'($urandom_range(5, 7)), pick_value());
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      burst_left = $urandom_range(1, 16);
      while (request_stream.size() > 0) begin
         item = request_stream.pop_front();
         req_if.valid    <= 1'b1;
         req_if.req_type <= item.code;
         req_if.value    <= item.value;
         do @(posedge clock); while (!req_if.ready);
         burst_left--;
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
         end
      end
      req_if.valid <= 1'b0;

      do @(posedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (check_failures == 0 && results_due == 0) begin
         $display("double_ended_queue regression: pass");
      end else begin
         $display("double_ended_queue regression: fail");
      end
      $finish;
   end

   // Result side: rotate a stall pattern per phase, with long hold-offs to back up the input.
   initial begin : result_drain
      logic [7:0] pattern;
      int         phase_left;
      int         hold_left;
      int         requests_seen;

      rsp_if.ready  = 1'b0;
      pattern       = 8'hFF;
      phase_left    = 0;
      hold_left     = 0;
      requests_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && req_if.valid && req_if.ready) begin
            requests_seen++;
            if (requests_seen == 60)       hold_left = 200;
            else if (requests_seen == 250) hold_left = 150;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            if (phase_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       pattern = 8'hFF;
                  1:       pattern = 8'($urandom);
                  2:       pattern = 8'($urandom) | 8'($urandom);
                  default: pattern = 8'($urandom) & 8'($urandom);
               endcase
               if (pattern == 8'h00) pattern = 8'h01;
               phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            rsp_if.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("double_ended_queue regression: fail");
      $finish;
   end

endmodule
